// ===== design/rssk_pkg.sv =====
// Package for the record selection sorter: field widths, default depth,
// the stored record type and the sequencer states. No dependencies.
`timescale 1ns / 1ps
package rssk_pkg;

	// Field widths of one record
	localparam int KEY_W = 30;
	localparam int TAG_W = 7;
	localparam int REC_W = KEY_W + TAG_W;

	// Default store depth
	localparam int MAX_RECORDS = 64;

	// One stored record, key in the upper bits
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} record_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_OUT_RD,
		ST_OUT_CAP,
		ST_OUT_HOLD
	} state_t;

endpackage

// ===== design/rssk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rssk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/record_selection_sort_by_key.sv =====
// Record selection sorter top level: load store, shared compare sequencer, output register.
// Depends on rssk_pkg and rssk_ram.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-----------------------------------------
//  records | rec_valid  | rec_stall  | sort_key, record_tag, final_record
//  sorted  | sort_valid | sort_stall | sorted_key, sorted_tag, end_of_run
//
// Loading accepts a record beat whenever rec_stall is low and writes it into the RAM. After
// the final beat the set of n records is sorted by one shared key comparator walking the
// RAM read port: pass i scans records i to n-1, then makes up to two swap writes (one RAM
// write port). Each sorted record is then read, captured and held until it is taken.
// rec_stall is high from the final beat until the last sorted beat is taken.
// Reset clears the sequencer and the record count; the RAM needs no clearing.
`timescale 1ns / 1ps
module record_selection_sort_by_key #(
	parameter int MAX_RECORDS = rssk_pkg::MAX_RECORDS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rec_valid,
	output logic                       rec_stall,
	input  logic [rssk_pkg::KEY_W-1:0] sort_key,
	input  logic [rssk_pkg::TAG_W-1:0] record_tag,
	input  logic                       final_record,
	output logic                       sort_valid,
	input  logic                       sort_stall,
	output logic [rssk_pkg::KEY_W-1:0] sorted_key,
	output logic [rssk_pkg::TAG_W-1:0] sorted_tag,
	output logic                       end_of_run
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	rssk_pkg::state_t  state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     pass_q;
	logic [CW-1:0]     rd_ptr_q;
	logic [CW-1:0]     rd_idx_s1;
	logic              rd_vld_s1;
	logic [CW-1:0]     best_idx_q;
	rssk_pkg::record_t best_q;
	rssk_pkg::record_t head_q;
	rssk_pkg::record_t rd_rec;
	rssk_pkg::record_t wr_rec;
	logic [rssk_pkg::REC_W-1:0] ram_rdata;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;

	logic              sort_valid_q;
	logic [rssk_pkg::KEY_W-1:0] sorted_key_q;
	logic [rssk_pkg::TAG_W-1:0] sorted_tag_q;
	logic              end_of_run_q;

	logic              store_room;
	logic [CW-1:0]     count_next;
	logic              more_pass;
	logic              scan_done;
	logic              emit_last;
	logic              no_swap;

	assign rd_rec = rssk_pkg::record_t'(ram_rdata);

	// shared status terms
	assign store_room = count_q < CW'(MAX_RECORDS);
	assign count_next = store_room ? CW'(count_q + CW'(1)) : count_q;
	assign more_pass  = ({1'b0, pass_q} + (CW+1)'(2)) < {1'b0, count_q};
	assign scan_done  = rd_vld_s1 && (CW'(rd_idx_s1 + CW'(1)) == count_q);
	assign emit_last  = CW'(rd_ptr_q + CW'(1)) == count_q;
	assign no_swap    = best_idx_q == pass_q;

	rssk_ram #(
		.WIDTH (rssk_pkg::REC_W),
		.DEPTH (MAX_RECORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_rec),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rssk_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_raddr = rd_ptr_q[AW-1:0];
		wr_rec    = '{key: sort_key, tag: record_tag};
		rec_stall = 1'b1;
		case (state_q)
			rssk_pkg::ST_LOAD: begin
				rec_stall = 1'b0;
				ram_we    = rec_valid && store_room;
				if (rec_valid && final_record) begin
					state_d = (count_next >= CW'(2)) ? rssk_pkg::ST_SCAN
					                                  : rssk_pkg::ST_OUT_RD;
				end
			end
			rssk_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = rssk_pkg::ST_SWAP_A;
				end
			end
			rssk_pkg::ST_SWAP_A: begin
				// old head goes to the minimum's slot
				ram_we    = !no_swap;
				ram_waddr = best_idx_q[AW-1:0];
				wr_rec    = head_q;
				if (!no_swap) begin
					state_d = rssk_pkg::ST_SWAP_B;
				end else begin
					state_d = more_pass ? rssk_pkg::ST_SCAN : rssk_pkg::ST_OUT_RD;
				end
			end
			rssk_pkg::ST_SWAP_B: begin
				// minimum goes to the head of the tail
				ram_we    = 1'b1;
				ram_waddr = pass_q[AW-1:0];
				wr_rec    = best_q;
				state_d   = more_pass ? rssk_pkg::ST_SCAN : rssk_pkg::ST_OUT_RD;
			end
			rssk_pkg::ST_OUT_RD: begin
				state_d = rssk_pkg::ST_OUT_CAP;
			end
			rssk_pkg::ST_OUT_CAP: begin
				state_d = rssk_pkg::ST_OUT_HOLD;
			end
			rssk_pkg::ST_OUT_HOLD: begin
				if (!sort_stall) begin
					state_d = end_of_run_q ? rssk_pkg::ST_LOAD : rssk_pkg::ST_OUT_RD;
				end
			end
			default: begin
				state_d = rssk_pkg::ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rd_vld_s1    <= 1'b0;
			sort_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == rssk_pkg::ST_SCAN) && (rd_ptr_q < count_q);
			case (state_q)
				rssk_pkg::ST_LOAD: begin
					if (rec_valid) begin
						count_q <= count_next;
					end
				end
				rssk_pkg::ST_OUT_CAP: begin
					sort_valid_q <= 1'b1;
				end
				rssk_pkg::ST_OUT_HOLD: begin
					if (!sort_stall) begin
						sort_valid_q <= 1'b0;
						if (end_of_run_q) begin
							count_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sort datapath: pointers, running minimum, output register
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q;
		case (state_q)
			rssk_pkg::ST_LOAD: begin
				pass_q   <= '0;
				rd_ptr_q <= '0;
			end
			rssk_pkg::ST_SCAN: begin
				if (rd_ptr_q < count_q) begin
					rd_ptr_q <= CW'(rd_ptr_q + CW'(1));
				end
				if (rd_vld_s1) begin
					if (rd_idx_s1 == pass_q) begin
						head_q     <= rd_rec;
						best_q     <= rd_rec;
						best_idx_q <= rd_idx_s1;
					end else if (best_q.key > rd_rec.key) begin
						best_q     <= rd_rec;
						best_idx_q <= rd_idx_s1;
					end
				end
			end
			rssk_pkg::ST_SWAP_A, rssk_pkg::ST_SWAP_B: begin
				if (state_q == rssk_pkg::ST_SWAP_B || no_swap) begin
					pass_q   <= CW'(pass_q + CW'(1));
					rd_ptr_q <= more_pass ? CW'(pass_q + CW'(1)) : '0;
				end
			end
			rssk_pkg::ST_OUT_CAP: begin
				sorted_key_q <= rd_rec.key;
				sorted_tag_q <= rd_rec.tag;
				end_of_run_q <= emit_last;
			end
			rssk_pkg::ST_OUT_HOLD: begin
				if (!sort_stall && !end_of_run_q) begin
					rd_ptr_q <= CW'(rd_ptr_q + CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign sort_valid = sort_valid_q;
	assign sorted_key = sorted_key_q;
	assign sorted_tag = sorted_tag_q;
	assign end_of_run = end_of_run_q;

endmodule
